FILE: sv/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// Shared reason codes for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package sip_pkg;

    typedef enum logic [1:0] {
        REASON_HIT      = 2'd0,
        REASON_DISJOINT = 2'd1,
        REASON_PARALLEL = 2'd2,
        REASON_RANGE    = 2'd3
    } reason_t;

endpackage

FILE: sv/sip_if.sv
// ----------------------------------------------------------------------------
// sip_in_if / sip_out_if
// Valid/ready channels carrying segment pairs and intersection results.
// ----------------------------------------------------------------------------
interface sip_in_if #(parameter int COORD_BITS = 16);
    logic valid;
    logic ready;
    logic signed [COORD_BITS-1:0] seg1_start_x;
    logic signed [COORD_BITS-1:0] seg1_start_y;
    logic signed [COORD_BITS-1:0] seg1_end_x;
    logic signed [COORD_BITS-1:0] seg1_end_y;
    logic signed [COORD_BITS-1:0] seg2_start_x;
    logic signed [COORD_BITS-1:0] seg2_start_y;
    logic signed [COORD_BITS-1:0] seg2_end_x;
    logic signed [COORD_BITS-1:0] seg2_end_y;
    modport source (output valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
                    seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y, input ready);
    modport sink (input valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
                  seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y, output ready);
endinterface

interface sip_out_if;
    logic valid;
    logic ready;
    logic hit;
    logic [1:0] reason;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    modport source (output valid, hit, reason, point_x, point_y, input ready);
    modport sink (input valid, hit, reason, point_x, point_y, output ready);
endinterface

FILE: sv/sip_div_stage.sv
// ----------------------------------------------------------------------------
// sip_div_stage
// One restoring-division step: shift remainder, compare, subtract, set bit.
// ----------------------------------------------------------------------------
module sip_div_stage #(
    parameter int RW = 34,
    parameter int QW = 17
) (
    input  logic [RW-1:0] rem,
    input  logic [RW-1:0] den,
    input  logic [QW-1:0] quo,
    output logic [RW-1:0] rem_out,
    output logic [QW-1:0] quo_out
);
    logic [RW:0] sh;
    assign sh = {rem, 1'b0};
    always_comb
    begin
        if (sh >= {1'b0, den})
        begin
            rem_out = RW'(sh - {1'b0, den});
            quo_out = {quo[QW-2:0], 1'b1};
        end
        else
        begin
            rem_out = sh[RW-1:0];
            quo_out = {quo[QW-2:0], 1'b0};
        end
    end
endmodule

FILE: sv/sip_front.sv
// ----------------------------------------------------------------------------
// sip_front
// Front stages: box test and differences, then products and range checks.
// ----------------------------------------------------------------------------
module sip_front #(
    parameter int COORD_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, ex, ey,
    output logic out_valid,
    output logic [1:0] out_reason,
    output logic [2*COORD_BITS+1:0] out_ns,
    output logic [2*COORD_BITS+1:0] out_det,
    output logic signed [COORD_BITS:0] out_rx,
    output logic signed [COORD_BITS:0] out_ry,
    output logic signed [COORD_BITS-1:0] out_ax,
    output logic signed [COORD_BITS-1:0] out_ay
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 3;

    logic signed [COORD_BITS-1:0] lox, hix, loy, hiy;
    logic disj;
    assign lox = (ax < bx) ? ax : bx;
    assign hix = (ax < bx) ? bx : ax;
    assign loy = (ay < by) ? ay : by;
    assign hiy = (ay < by) ? by : ay;
    assign disj = (cx < lox && ex < lox) || (cx > hix && ex > hix)
                || (cy < loy && ey < loy) || (cy > hiy && ey > hiy);

    logic v1_reg, disj1_reg;
    logic signed [DW-1:0] rx1_reg, ry1_reg, ux1_reg, uy1_reg, wx1_reg, wy1_reg;
    logic signed [COORD_BITS-1:0] ax1_reg, ay1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            disj1_reg <= disj;
            rx1_reg <= DW'(bx) - DW'(ax);
            ry1_reg <= DW'(by) - DW'(ay);
            ux1_reg <= DW'(ex) - DW'(cx);
            uy1_reg <= DW'(ey) - DW'(cy);
            wx1_reg <= DW'(cx) - DW'(ax);
            wy1_reg <= DW'(cy) - DW'(ay);
            ax1_reg <= ax;
            ay1_reg <= ay;
        end
    end

    // stage 2: six products
    logic v2_reg, disj2_reg;
    logic signed [PW-2:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [DW-1:0] rx2_reg, ry2_reg;
    logic signed [COORD_BITS-1:0] ax2_reg, ay2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            disj2_reg <= disj1_reg;
            p0_reg <= (PW-1)'(ux1_reg * ry1_reg);
            p1_reg <= (PW-1)'(uy1_reg * rx1_reg);
            p2_reg <= (PW-1)'(ux1_reg * wy1_reg);
            p3_reg <= (PW-1)'(uy1_reg * wx1_reg);
            p4_reg <= (PW-1)'(rx1_reg * wy1_reg);
            p5_reg <= (PW-1)'(ry1_reg * wx1_reg);
            rx2_reg <= rx1_reg;
            ry2_reg <= ry1_reg;
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
        end
    end

    // stage 3: differences, sign normalize, checks
    logic signed [PW-1:0] det, ns, nt, adet, ans, ant;
    logic [1:0] rsn;
    assign det = PW'(p0_reg) - PW'(p1_reg);
    assign ns  = PW'(p2_reg) - PW'(p3_reg);
    assign nt  = PW'(p4_reg) - PW'(p5_reg);
    assign adet = det[PW-1] ? -det : det;
    assign ans  = det[PW-1] ? -ns : ns;
    assign ant  = det[PW-1] ? -nt : nt;

    always_comb
    begin
        priority if (disj2_reg)
            rsn = sip_pkg::REASON_DISJOINT;
        else if (det == '0)
            rsn = sip_pkg::REASON_PARALLEL;
        else if (ans < 0 || ans > adet || ant < 0 || ant > adet)
            rsn = sip_pkg::REASON_RANGE;
        else
            rsn = sip_pkg::REASON_HIT;
    end

    logic v3_reg;
    logic [1:0] rsn3_reg;
    logic [PW-2:0] ns3_reg, det3_reg;
    logic signed [DW-1:0] rx3_reg, ry3_reg;
    logic signed [COORD_BITS-1:0] ax3_reg, ay3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsn3_reg <= rsn;
            ns3_reg  <= ans[PW-2:0];
            det3_reg <= adet[PW-2:0];
            rx3_reg <= rx2_reg;
            ry3_reg <= ry2_reg;
            ax3_reg <= ax2_reg;
            ay3_reg <= ay2_reg;
        end
    end

    assign out_valid  = v3_reg;
    assign out_reason = rsn3_reg;
    assign out_ns     = ns3_reg;
    assign out_det    = det3_reg;
    assign out_rx     = rx3_reg;
    assign out_ry     = ry3_reg;
    assign out_ax     = ax3_reg;
    assign out_ay     = ay3_reg;
endmodule

FILE: sv/sip_back.sv
// ----------------------------------------------------------------------------
// sip_back
// Pipelined fraction divider (one bit per stage) and point reconstruction.
// ----------------------------------------------------------------------------
module sip_back #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic [1:0] in_reason,
    input  logic [2*COORD_BITS+1:0] in_ns,
    input  logic [2*COORD_BITS+1:0] in_det,
    input  logic signed [COORD_BITS:0] in_rx,
    input  logic signed [COORD_BITS:0] in_ry,
    input  logic signed [COORD_BITS-1:0] in_ax,
    input  logic signed [COORD_BITS-1:0] in_ay,
    output logic out_valid,
    output logic out_hit,
    output logic [1:0] out_reason,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y
);
    localparam int RW = 2 * COORD_BITS + 2;
    localparam int QW = FRAC_BITS + 1;
    localparam int DW = COORD_BITS + 1;
    localparam int NS = FRAC_BITS + 1;
    localparam int MW = DW + QW + 1;
    localparam int XW = COORD_BITS + FRAC_BITS + 2;
    localparam int OW = (XW > MW) ? XW : MW;

    logic              v_reg   [NS];
    logic        [1:0] rsn_reg [NS];
    logic              full_reg[NS];
    logic     [RW-1:0] rem_reg [NS];
    logic     [RW-1:0] den_reg [NS];
    logic     [QW-1:0] quo_reg [NS];
    logic signed [DW-1:0] rx_reg [NS];
    logic signed [DW-1:0] ry_reg [NS];
    logic signed [COORD_BITS-1:0] ax_reg [NS];
    logic signed [COORD_BITS-1:0] ay_reg [NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsn_reg[0]  <= in_reason;
            full_reg[0] <= (in_ns >= in_det);
            rem_reg[0]  <= in_ns;
            den_reg[0]  <= in_det;
            quo_reg[0]  <= '0;
            rx_reg[0] <= in_rx;
            ry_reg[0] <= in_ry;
            ax_reg[0] <= in_ax;
            ay_reg[0] <= in_ay;
        end
    end

    genvar g;
    generate
        for (g = 1; g < NS; g++)
        begin : g_div
            logic [RW-1:0] rem_n;
            logic [QW-1:0] quo_n;
            sip_div_stage #(.RW(RW), .QW(QW)) u_stage (
                .rem(rem_reg[g-1]), .den(den_reg[g-1]), .quo(quo_reg[g-1]),
                .rem_out(rem_n), .quo_out(quo_n)
            );
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rsn_reg[g]  <= rsn_reg[g-1];
                    full_reg[g] <= full_reg[g-1];
                    rem_reg[g]  <= rem_n;
                    den_reg[g]  <= den_reg[g-1];
                    quo_reg[g]  <= quo_n;
                    rx_reg[g] <= rx_reg[g-1];
                    ry_reg[g] <= ry_reg[g-1];
                    ax_reg[g] <= ax_reg[g-1];
                    ay_reg[g] <= ay_reg[g-1];
                end
            end
        end
    endgenerate

    // multiply stage
    logic [QW-1:0] q;
    assign q = full_reg[NS-1] ? QW'(1) << FRAC_BITS : quo_reg[NS-1];

    logic vm_reg;
    logic [1:0] rsnm_reg;
    logic signed [MW-1:0] mx_reg, my_reg;
    logic signed [COORD_BITS-1:0] axm_reg, aym_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else if (en)
            vm_reg <= v_reg[NS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsnm_reg <= rsn_reg[NS-1];
            mx_reg <= MW'(rx_reg[NS-1]) * MW'($signed({1'b0, q}));
            my_reg <= MW'(ry_reg[NS-1]) * MW'($signed({1'b0, q}));
            axm_reg <= ax_reg[NS-1];
            aym_reg <= ay_reg[NS-1];
        end
    end

    // add stage
    logic signed [OW-1:0] sx, sy;
    logic hitm;
    assign sx = (OW'(axm_reg) <<< FRAC_BITS) + OW'(mx_reg);
    assign sy = (OW'(aym_reg) <<< FRAC_BITS) + OW'(my_reg);
    assign hitm = (rsnm_reg == sip_pkg::REASON_HIT);

    logic vo_reg, hit_reg;
    logic [1:0] rsno_reg;
    logic signed [31:0] x_reg, y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= vm_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hitm;
            rsno_reg <= rsnm_reg;
            x_reg <= hitm ? 32'(sx) : '0;
            y_reg <= hitm ? 32'(sy) : '0;
        end
    end

    assign out_valid  = vo_reg;
    assign out_hit    = hit_reg;
    assign out_reason = rsno_reg;
    assign out_x      = x_reg;
    assign out_y      = y_reg;
endmodule

FILE: sv/segment_intersection_point_top.sv
// ----------------------------------------------------------------------------
// segment_intersection_point_top
// Segment pair intersection test with Q16.16 intersection point.
// ----------------------------------------------------------------------------
// One word in and one word out per cycle unless the output stalls. The stages:
// three front stages (box test and differences, cross products, range
// checks), one divider input stage holding the full-range compare,
// FRAC_BITS restoring-division stages producing one quotient bit each,
// a multiply stage and an add stage. A stall freezes the whole
// pipeline; the output register accepts new data whenever it is empty or
// being read.
module segment_intersection_point_top #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,
    sip_in_if.sink    in_ch,
    sip_out_if.source out_ch
);
    logic en;
    logic fv;
    logic [1:0] frsn;
    logic [2*COORD_BITS+1:0] fns, fdet;
    logic signed [COORD_BITS:0] frx, fry;
    logic signed [COORD_BITS-1:0] fax, fay;

    assign en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    sip_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_ch.valid),
        .ax(in_ch.seg1_start_x), .ay(in_ch.seg1_start_y),
        .bx(in_ch.seg1_end_x), .by(in_ch.seg1_end_y),
        .cx(in_ch.seg2_start_x), .cy(in_ch.seg2_start_y),
        .ex(in_ch.seg2_end_x), .ey(in_ch.seg2_end_y),
        .out_valid(fv), .out_reason(frsn), .out_ns(fns), .out_det(fdet),
        .out_rx(frx), .out_ry(fry), .out_ax(fax), .out_ay(fay)
    );

    sip_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(fv),
        .in_reason(frsn), .in_ns(fns), .in_det(fdet),
        .in_rx(frx), .in_ry(fry), .in_ax(fax), .in_ay(fay),
        .out_valid(out_ch.valid), .out_hit(out_ch.hit), .out_reason(out_ch.reason),
        .out_x(out_ch.point_x), .out_y(out_ch.point_y)
    );
endmodule
